>>> rtl/tass_pkg.sv
// ----------------------------------------------------------------------------
// tass_pkg
// Shared types, widths and the full-step coil tables of the two-axis stepper
// step engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tass_pkg;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned MM_W    = 16;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned COIL_W  = 4;
  localparam int unsigned PHASE_W = 2;

  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 88;

  localparam logic [COUNT_W-1:0] STEPS_PER_MM_RESET = 16'd80;

  localparam logic [PHASE_W-1:0] PHASE_LAST = 2'd3;

  // Snapshot of one request as it is handed to the output stage.
  typedef struct packed {
    logic                    blocked;
    logic                    fwd;
    logic                    enable_x;
    logic [COIL_W-1:0]       coil_hold;
    logic signed [POS_W-1:0] x_steps;
    logic signed [POS_W-1:0] y_steps;
    logic signed [MM_W-1:0]  x_mm;
    logic signed [MM_W-1:0]  y_mm;
  } snap_t;

  // Two-phase full-step patterns: forward AB, BC, CD, DA; backward AD, CD, BC, AB.
  function automatic logic [COIL_W-1:0] coil_of(input logic fwd,
                                                input logic [PHASE_W-1:0] phase);
    logic [COIL_W-1:0] pat;
    unique case (phase)
      2'd0:    pat = fwd ? 4'h3 : 4'h9;
      2'd1:    pat = fwd ? 4'h6 : 4'hC;
      2'd2:    pat = fwd ? 4'hC : 4'h6;
      default: pat = fwd ? 4'h9 : 4'h3;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

>>> rtl/tass_phase_gen.sv
// ----------------------------------------------------------------------------
// tass_phase_gen
// Output stage: holds one request snapshot and plays out its coil words,
// one per beat, with the status flag and the last marker.
// ----------------------------------------------------------------------------
`default_nettype none

module tass_phase_gen
  import tass_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire snap_t                load_snap,
  output logic                      load_ready,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // coil_pattern[3:0], enable_x[4], x_steps[28:5], y_steps[52:29],
  // x_mm[68:53], y_mm[84:69], zero fill above
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  // status
  output logic                      m_axis_tuser,
  output logic                      m_axis_tlast
);

  logic               busy;
  logic [PHASE_W-1:0] phase;
  snap_t              snap;
  logic [COIL_W-1:0]  coil;
  logic               beat;

  assign coil          = snap.blocked ? snap.coil_hold : coil_of(snap.fwd, phase);
  assign m_axis_tvalid = busy;
  assign m_axis_tlast  = snap.blocked || (phase == PHASE_LAST);
  assign m_axis_tuser  = snap.blocked;
  assign m_axis_tdata  = {3'b000, snap.y_mm, snap.x_mm, snap.y_steps, snap.x_steps,
                          snap.enable_x, coil};
  assign beat          = busy && m_axis_tready;

  // A new request may be loaded while the final word of the current one leaves.
  assign load_ready = !busy || (beat && m_axis_tlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= '0;
    end else if (load) begin
      busy  <= 1'b1;
      phase <= '0;
    end else if (beat) begin
      if (m_axis_tlast) begin
        busy  <= 1'b0;
        phase <= '0;
      end else begin
        phase <= phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      snap <= load_snap;
    end
  end

  a_phase_busy: assert property (@(posedge clk) disable iff (rst)
    (phase != 2'd0) |-> busy)
    else $error("phase counter running with no request held");

  a_blocked_single: assert property (@(posedge clk) disable iff (rst)
    (busy && snap.blocked) |-> (phase == 2'd0))
    else $error("blocked request advanced past its single word");

  a_phase_advance: assert property (@(posedge clk) disable iff (rst)
    (beat && !m_axis_tlast) |=> (busy && (phase == $past(phase) + 2'd1)))
    else $error("coil sequence did not advance after a non-final word");

endmodule

`default_nettype wire

>>> rtl/two_axis_stepper_step_engine.sv
// ----------------------------------------------------------------------------
// two_axis_stepper_step_engine
// Full-step sequencer for two stepper axes with limit sensing and step and
// millimetre position tracking.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries step requests: tuser is the axis (0 X, 1 Y), tdata holds
//   the direction and the four active-low limit levels. m_axis returns the
//   coil words with positions; tuser is the blocked flag, tlast ends a request.
//   cfg_we with cfg_wdata writes steps_per_mm; write it only while idle.
// Latency: the first word of a request is valid the cycle after acceptance.
// Throughput: a taken step yields four words, one per cycle while m_axis_tready
//   is high; a blocked step yields one word. The phase counter of the output
//   stage sets this rate, and the next request is taken in the cycle the final
//   word leaves.
// Reset: positions, counters and coordinates clear, coils off, driver select
//   on Y, steps_per_mm returns to 80, and no word is pending.
// Stall: while m_axis_tready is low the current word holds and s_axis_tready
//   stays low until the final word of the request has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module two_axis_stepper_step_engine
  import tass_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [COUNT_W-1:0]   cfg_wdata,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // step_forward[0], limit_x_low_end[1], limit_x_high_end[2],
  // limit_y_high_end[3], limit_y_low_end[4], zero fill above
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // axis_sel
  input  wire logic                 s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // coil_pattern[3:0], enable_x[4], x_steps[28:5], y_steps[52:29],
  // x_mm[68:53], y_mm[84:69], zero fill above
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  // status
  output logic                      m_axis_tuser,
  output logic                      m_axis_tlast
);

  logic [COUNT_W-1:0] steps_per_mm;
  logic [POS_W-1:0]   x_position, x_position_next;
  logic [POS_W-1:0]   y_position, y_position_next;
  logic [COUNT_W-1:0] x_step_count, x_step_count_next;
  logic [COUNT_W-1:0] y_step_count, y_step_count_next;
  logic [MM_W-1:0]    x_coordinate, x_coordinate_next;
  logic [MM_W-1:0]    y_coordinate, y_coordinate_next;
  logic [COIL_W-1:0]  coil_hold;
  logic               enable_hold;

  logic               is_y, fwd, clear, accept, take_step;
  logic [COUNT_W-1:0] x_count_inc, y_count_inc;
  logic [POS_W-1:0]   pos_delta;
  logic [MM_W-1:0]    mm_delta;
  snap_t              snap;
  logic               load_ready;

  assign is_y   = s_axis_tuser;
  assign fwd    = s_axis_tdata[0];
  assign clear  = is_y ? (fwd ? s_axis_tdata[3] : s_axis_tdata[4])
                       : (fwd ? s_axis_tdata[2] : s_axis_tdata[1]);
  assign s_axis_tready = load_ready;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign take_step = accept && clear;

  assign pos_delta = fwd ? {{(POS_W-1){1'b0}}, 1'b1} : {POS_W{1'b1}};
  assign mm_delta  = fwd ? {{(MM_W-1){1'b0}}, 1'b1} : {MM_W{1'b1}};

  always_comb begin
    x_position_next = x_position;
    y_position_next = y_position;
    x_count_inc     = x_step_count;
    y_count_inc     = y_step_count;
    if (is_y) begin
      y_position_next = y_position + pos_delta;
      y_count_inc     = y_step_count + 16'd1;
    end else begin
      x_position_next = x_position + pos_delta;
      x_count_inc     = x_step_count + 16'd1;
    end
    // Both counters are tested, so the idle axis can match after a rewrite
    // of steps_per_mm and then moves in the direction of this step.
    x_step_count_next = x_count_inc;
    x_coordinate_next = x_coordinate;
    if (x_count_inc == steps_per_mm) begin
      x_step_count_next = '0;
      x_coordinate_next = x_coordinate + mm_delta;
    end
    y_step_count_next = y_count_inc;
    y_coordinate_next = y_coordinate;
    if (y_count_inc == steps_per_mm) begin
      y_step_count_next = '0;
      y_coordinate_next = y_coordinate + mm_delta;
    end
  end

  always_comb begin
    snap.blocked  = !clear;
    snap.fwd      = fwd;
    snap.coil_hold = coil_hold;
    if (clear) begin
      snap.enable_x = !is_y;
      snap.x_steps  = x_position_next;
      snap.y_steps  = y_position_next;
      snap.x_mm     = x_coordinate_next;
      snap.y_mm     = y_coordinate_next;
    end else begin
      snap.enable_x = enable_hold;
      snap.x_steps  = x_position;
      snap.y_steps  = y_position;
      snap.x_mm     = x_coordinate;
      snap.y_mm     = y_coordinate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_mm <= STEPS_PER_MM_RESET;
    end else if (cfg_we) begin
      steps_per_mm <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_position   <= '0;
      y_position   <= '0;
      x_step_count <= '0;
      y_step_count <= '0;
      x_coordinate <= '0;
      y_coordinate <= '0;
      coil_hold    <= '0;
      enable_hold  <= 1'b0;
    end else if (take_step) begin
      x_position   <= x_position_next;
      y_position   <= y_position_next;
      x_step_count <= x_step_count_next;
      y_step_count <= y_step_count_next;
      x_coordinate <= x_coordinate_next;
      y_coordinate <= y_coordinate_next;
      coil_hold    <= coil_of(fwd, PHASE_LAST);
      enable_hold  <= !is_y;
    end
  end

  tass_phase_gen u_phase_gen (
    .clk           (clk),
    .rst           (rst),
    .load          (accept),
    .load_snap     (snap),
    .load_ready    (load_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_hold_pattern: assert property (@(posedge clk) disable iff (rst)
    take_step |=> (coil_hold == coil_of($past(fwd), PHASE_LAST)))
    else $error("held coil pattern is not the final phase of the step");

  a_blocked_frozen: assert property (@(posedge clk) disable iff (rst)
    (accept && !clear) |=> ($stable(x_position) && $stable(y_position)
                            && $stable(x_coordinate) && $stable(y_coordinate)))
    else $error("blocked step changed the position state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    take_step |=> ((x_step_count != steps_per_mm) && (y_step_count != steps_per_mm)))
    else $error("step counter left equal to steps_per_mm after a step");

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives step requests into the two-axis stepper step engine and checks every
// coil word against a cycle-free predictor of positions, millimetre
// coordinates and coil phases, under random gaps on both stream sides.
// ----------------------------------------------------------------------------

module testbench;

  import tass_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;
  localparam logic DIR_BWD = 1'b0;
  localparam logic DIR_FWD = 1'b1;
  localparam logic STATUS_TAKEN = 1'b0;
  localparam logic STATUS_BLOCKED = 1'b1;

  localparam logic [COIL_W-1:0] COIL_OFF = 4'h0;
  localparam logic [COIL_W-1:0] COIL_AB = 4'h3;
  localparam logic [COIL_W-1:0] COIL_BC = 4'h6;
  localparam logic [COIL_W-1:0] COIL_CD = 4'hC;
  localparam logic [COIL_W-1:0] COIL_DA = 4'h9;

  localparam logic [COIL_W-1:0] FWD_PHASES [4] = '{COIL_AB, COIL_BC, COIL_CD, COIL_DA};
  localparam logic [COIL_W-1:0] BWD_PHASES [4] = '{COIL_DA, COIL_CD, COIL_BC, COIL_AB};

  typedef struct packed {
    logic axis;
    logic fwd;
    logic x_lo;
    logic x_hi;
    logic y_hi;
    logic y_lo;
  } step_req_t;

  typedef struct packed {
    logic [COIL_W-1:0]       coil;
    logic                    enable_x;
    logic                    status;
    logic signed [POS_W-1:0] x_steps;
    logic signed [POS_W-1:0] y_steps;
    logic signed [MM_W-1:0]  x_mm;
    logic signed [MM_W-1:0]  y_mm;
    logic                    last;
  } coil_word_t;

  typedef enum logic {ROW_STEP, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [COUNT_W-1:0] spm;
    step_req_t          req;
    logic               typed;
    coil_word_t         want;
  } plan_row_t;

  localparam coil_word_t NO_WORD = '0;

  // Where typed is set, want is the first word of the request as it must read.
  plan_row_t directed_plan [0:20] = '{
    '{ROW_STEP, 16'd0, '{AXIS_X, DIR_FWD, 1'b1, 1'b0, 1'b1, 1'b1}, 1'b1,
      '{COIL_OFF, 1'b0, STATUS_BLOCKED, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 1'b1}},
    '{ROW_STEP, 16'd0, '{AXIS_Y, DIR_BWD, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b1,
      '{COIL_OFF, 1'b0, STATUS_BLOCKED, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 1'b1}},
    '{ROW_STEP, 16'd0, '{AXIS_X, DIR_FWD, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{COIL_AB, 1'b1, STATUS_TAKEN, 24'sd1, 24'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{ROW_STEP, 16'd0, '{AXIS_X, DIR_BWD, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{COIL_DA, 1'b1, STATUS_TAKEN, 24'sd0, 24'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{ROW_STEP, 16'd0, '{AXIS_X, DIR_BWD, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{COIL_DA, 1'b1, STATUS_TAKEN, -24'sd1, 24'sd0, 16'sd0, 16'sd0, 1'b0}},
    '{ROW_STEP, 16'd0, '{AXIS_Y, DIR_FWD, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b1,
      '{COIL_AB, 1'b0, STATUS_TAKEN, -24'sd1, 24'sd1, 16'sd0, 16'sd0, 1'b0}},
    '{ROW_STEP, 16'd0, '{AXIS_Y, DIR_FWD, 1'b1, 1'b1, 1'b0, 1'b1}, 1'b1,
      '{COIL_DA, 1'b0, STATUS_BLOCKED, -24'sd1, 24'sd1, 16'sd0, 16'sd0, 1'b1}},
    '{ROW_STEP, 16'd0, '{AXIS_X, DIR_BWD, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{COIL_DA, 1'b0, STATUS_BLOCKED, -24'sd1, 24'sd1, 16'sd0, 16'sd0, 1'b1}},
    // The X count already stands at three, so the next Y step moves X too.
    '{ROW_CFG, 16'd3, '0, 1'b0, NO_WORD},
    '{ROW_STEP, 16'd0, '{AXIS_Y, DIR_BWD, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_WORD},
    '{ROW_CFG, 16'd1, '0, 1'b0, NO_WORD},
    '{ROW_STEP, 16'd0, '{AXIS_X, DIR_FWD, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_WORD},
    '{ROW_STEP, 16'd0, '{AXIS_Y, DIR_FWD, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_WORD},
    '{ROW_STEP, 16'd0, '{AXIS_X, DIR_BWD, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_WORD},
    '{ROW_STEP, 16'd0, '{AXIS_Y, DIR_BWD, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, NO_WORD},
    '{ROW_CFG, 16'd65535, '0, 1'b0, NO_WORD},
    '{ROW_STEP, 16'd0, '{AXIS_X, DIR_FWD, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_WORD},
    '{ROW_STEP, 16'd0, '{AXIS_Y, DIR_BWD, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_WORD},
    '{ROW_STEP, 16'd0, '{AXIS_X, DIR_FWD, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, NO_WORD},
    '{ROW_STEP, 16'd0, '{AXIS_Y, DIR_FWD, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_WORD},
    '{ROW_CFG, 16'd80, '0, 1'b0, NO_WORD}
  };

  logic [COUNT_W-1:0] phase_spm [7] = '{16'd2, 16'd1, 16'd7, 16'd65535, 16'd80, 16'd0,
                                        16'd3};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [COUNT_W-1:0]   cfg_wdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  two_axis_stepper_step_engine u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted machine state.
  logic [COUNT_W-1:0] spm_now;
  logic [POS_W-1:0]   x_pos, y_pos;
  logic [COUNT_W-1:0] x_count, y_count;
  logic [MM_W-1:0]    x_coord, y_coord;
  logic [COIL_W-1:0]  coil_now;
  logic               driver_x;

  coil_word_t coil_words_due [$];
  int         failures = 0;
  int         cycles = 0;
  int         stall_left = 0;
  int         calm_left = 0;

  task automatic reset_axes();
    spm_now = STEPS_PER_MM_RESET;
    x_pos = '0;
    y_pos = '0;
    x_count = '0;
    y_count = '0;
    x_coord = '0;
    y_coord = '0;
    coil_now = COIL_OFF;
    driver_x = 1'b0;
  endtask

  // Applies one request to the predicted state and returns the words it causes.
  function automatic int advance_axes(input step_req_t r, output coil_word_t words [4]);
    logic clear;
    clear = (r.axis == AXIS_X) ? (r.fwd ? r.x_hi : r.x_lo) : (r.fwd ? r.y_hi : r.y_lo);
    if (!clear) begin
      words[0] = '{coil_now, driver_x, STATUS_BLOCKED, x_pos, y_pos, x_coord, y_coord, 1'b1};
      return 1;
    end
    if (r.axis == AXIS_X) begin
      driver_x = 1'b1;
      x_pos = r.fwd ? x_pos + 1'b1 : x_pos - 1'b1;
      x_count = x_count + 1'b1;
    end else begin
      driver_x = 1'b0;
      y_pos = r.fwd ? y_pos + 1'b1 : y_pos - 1'b1;
      y_count = y_count + 1'b1;
    end
    // Both counters are compared, whichever axis moved.
    if (x_count == spm_now) begin
      x_coord = r.fwd ? x_coord + 1'b1 : x_coord - 1'b1;
      x_count = '0;
    end
    if (y_count == spm_now) begin
      y_coord = r.fwd ? y_coord + 1'b1 : y_coord - 1'b1;
      y_count = '0;
    end
    for (int k = 0; k < 4; k++) begin
      coil_now = r.fwd ? FWD_PHASES[k] : BWD_PHASES[k];
      words[k] = '{coil_now, driver_x, STATUS_TAKEN, x_pos, y_pos, x_coord, y_coord,
                   k == 3};
    end
    return 4;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Called just after a rising edge; returns at the edge that accepts the word.
  task automatic send_step(input step_req_t r, input int gap, input logic typed,
                           input coil_word_t want);
    logic [S_TDATA_W-1:0] td;
    coil_word_t words [4];
    int n;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    td = '0;
    td[4:0] = {r.y_lo, r.y_hi, r.x_hi, r.x_lo, r.fwd};
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= td;
    s_axis_tuser <= r.axis;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n = advance_axes(r, words);
    if (typed) words[0] = want;
    for (int k = 0; k < n; k++) coil_words_due.push_back(words[k]);
  endtask

  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    while (coil_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_steps_per_mm(input logic [COUNT_W-1:0] value);
    drain_outputs();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    spm_now = value;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      failures++;
    end
  endtask

  initial begin : stimulus
    step_req_t r;
    logic [5:0] bits;
    int bias;
    int gap;
    bit calm;
    reset_axes();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        write_steps_per_mm(directed_plan[i].spm);
      end else begin
        send_step(directed_plan[i].req, pick_gap(), directed_plan[i].typed,
                  directed_plan[i].want);
      end
    end

    for (int p = 0; p < 7; p++) begin
      write_steps_per_mm((p == 5) ? COUNT_W'($urandom_range(1, 20)) : phase_spm[p]);
      // A strong lean one way lets the coordinates travel well away from zero.
      bias = $urandom_range(15, 85);
      calm = (p == 2);
      for (int i = 0; i < 60; i++) begin
        bits = 6'($urandom);
        r = bits;
        r.fwd = ($urandom_range(0, 99) < bias) ? DIR_FWD : DIR_BWD;
        if ($urandom_range(0, 99) < 80) begin
          if (r.axis == AXIS_X) begin
            if (r.fwd) r.x_hi = 1'b1;
            else r.x_lo = 1'b1;
          end else if (r.fwd) begin
            r.y_hi = 1'b1;
          end else begin
            r.y_lo = 1'b1;
          end
        end
        if ($urandom_range(0, 99) == 0) drain_outputs();
        gap = calm ? 0 : pick_gap();
        send_step(r, gap, 1'b0, NO_WORD);
      end
    end

    drain_outputs();
    repeat (8) @(posedge clk);
    if (failures == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin : output_side
    coil_word_t got;
    coil_word_t due;
    int roll;
    if (calm_left > 0) begin
      calm_left = calm_left - 1;
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        m_axis_tready <= 1'b1;
      end else if (roll < 90) begin
        stall_left = $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else if (roll < 96) begin
        stall_left = $urandom_range(5, 25);
        m_axis_tready <= 1'b0;
      end else begin
        calm_left = $urandom_range(20, 80);
        m_axis_tready <= 1'b1;
      end
    end

    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.coil = m_axis_tdata[3:0];
      got.enable_x = m_axis_tdata[4];
      got.x_steps = m_axis_tdata[28:5];
      got.y_steps = m_axis_tdata[52:29];
      got.x_mm = m_axis_tdata[68:53];
      got.y_mm = m_axis_tdata[84:69];
      got.status = m_axis_tuser;
      got.last = m_axis_tlast;
      if (coil_words_due.size() == 0) begin
        $display("%0t: coil word with nothing expected, tdata %h", $time, m_axis_tdata);
        failures++;
      end else begin
        due = coil_words_due.pop_front();
        check_field("coil_pattern", due.coil, got.coil);
        check_field("enable_x", due.enable_x, got.enable_x);
        check_field("status", due.status, got.status);
        check_field("x_steps", due.x_steps, got.x_steps);
        check_field("y_steps", due.y_steps, got.y_steps);
        check_field("x_mm", due.x_mm, got.x_mm);
        check_field("y_mm", due.y_mm, got.y_mm);
        check_field("last", due.last, got.last);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

>>> two_axis_stepper_step_engine.f
rtl/tass_pkg.sv
rtl/tass_phase_gen.sv
rtl/two_axis_stepper_step_engine.sv
verif/testbench.sv
